// ===== design/arpc_pkg.sv =====
// Package for the ARP cache core: fixed sizes, command, result and config codes,
// beat and memory word types and the sequencer states. No dependencies.
`timescale 1ns / 1ps
package arpc_pkg;

  localparam int CACHE_DEPTH = 16;
  localparam int PEND_DEPTH  = 8;
  localparam int CIDX_W      = 4;
  localparam int PIDX_W      = 3;
  localparam int CCNT_W      = 5;
  localparam int RANK_W      = 3;

  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_QUEUE  = 2'd2;
  localparam logic [1:0] CMD_TICK   = 2'd3;

  localparam logic [2:0] KIND_HIT       = 3'd0;
  localparam logic [2:0] KIND_MISS      = 3'd1;
  localparam logic [2:0] KIND_INSERTED  = 3'd2;
  localparam logic [2:0] KIND_QUEUED    = 3'd3;
  localparam logic [2:0] KIND_SEND      = 3'd4;
  localparam logic [2:0] KIND_GIVE_UP   = 3'd5;
  localparam logic [2:0] KIND_TICK_DONE = 3'd6;

  localparam logic [1:0] CFG_LIFETIME   = 2'd0;
  localparam logic [1:0] CFG_SEND_LIMIT = 2'd1;
  localparam logic [1:0] CFG_RETRY_GAP  = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] ip_addr;
    logic [47:0] mac_addr;
    logic        with_packet;
  } item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] ip_out;
    logic [47:0] mac_out;
    logic        stored;
    logic        pending_found;
    logic [7:0]  packet_count;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
    logic [31:0] stamp;
  } cache_word_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [2:0]  sends;
    logic [31:0] sent_at;
    logic [7:0]  packets;
  } pend_word_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CSCAN, ST_PSCAN, ST_FINISH, ST_TSEL, ST_TEVAL, ST_TDONE
  } state_t;

endpackage

// ===== design/arp_cache_with_request_retry_core.sv =====
// ARP cache core: cache and pending-request memories with a scan sequencer.
// Depends on arpc_pkg.
`timescale 1ns / 1ps
// Usage:
//   An item (item: cmd, ip_addr, mac_addr, with_packet) is taken when start is
//   high and busy is low. Each result beat appears on result for one cycle
//   with result_valid high; result.last marks the final beat of the item.
//   The receiver cannot stall; results are never held back.
//   Config: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
//   always high. Index 0 entry_lifetime, 1 send_limit, 2 retry_gap.
//   Sequence, set by the one-entry-per-cycle scans of the cache and request
//   memories (one read port each, registered read data):
//     lookup: a cache scan from accept, then the result beat
//     insert, queue: a request table scan, then the result beat
//     tick: a cache aging scan, then for each rank slot a select step, plus an
//     evaluate step where a request holds that rank, then the tick done beat.
//   busy falls in the cycle the final beat shows, so the next item may follow.
//   Reset (rst, synchronous) clears the cache and request valid bits and the seconds
//   counter and loads the register defaults 15, 5 and 1; no clearing pass is needed.
module arp_cache_with_request_retry_core import arpc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  item_t       item,
  output logic        result_valid,
  output result_t     result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  state_t state, state_next;
  item_t  cur;

  logic [15:0] entry_lifetime;
  logic [2:0]  send_limit;
  logic [7:0]  retry_gap;
  logic [31:0] seconds_now;

  logic [CACHE_DEPTH-1:0] entry_valid;
  logic [PEND_DEPTH-1:0]  pend_valid;
  logic [RANK_W-1:0]      pend_rank [PEND_DEPTH];
  logic [PEND_DEPTH-1:0]  snap_valid;
  logic [RANK_W-1:0]      snap_rank [PEND_DEPTH];

  cache_word_t cmem [CACHE_DEPTH];
  pend_word_t  pmem [PEND_DEPTH];
  cache_word_t c_rd;
  pend_word_t  p_rd;

  logic [CCNT_W-1:0] cnt;
  logic              rv;
  logic [CIDX_W-1:0] ridx;

  logic              hit;
  logic [47:0]       hit_mac;
  logic              found;
  logic [PIDX_W-1:0] best_slot;
  logic [RANK_W-1:0] best_rank;
  pend_word_t        best_word;
  logic [RANK_W-1:0] k;
  logic [PIDX_W-1:0] tslot;

  logic [CIDX_W-1:0] c_free;
  logic              c_has;
  logic [PIDX_W-1:0] p_free;
  logic              p_has;
  logic [PIDX_W-1:0] sel_slot;
  logic              sel_ok;
  logic [CIDX_W-1:0] c_raddr;
  logic [PIDX_W-1:0] p_raddr;
  logic              c_we, p_we;
  logic [PIDX_W-1:0] p_waddr;
  pend_word_t        p_wdata;
  cache_word_t       c_wdata;
  logic [7:0]        q_pkts;
  logic              due, give_up, k_last;
  logic [PIDX_W-1:0] pidx;
  result_t           result_next;
  logic              result_valid_next;

  assign pidx   = ridx[PIDX_W-1:0];
  assign k_last = (k == RANK_W'(PEND_DEPTH - 1));

  always_comb begin
    c_free = '0;
    c_has  = 1'b0;
    for (int i = CACHE_DEPTH - 1; i >= 0; i--) begin
      if (!entry_valid[i]) begin
        c_free = CIDX_W'(i);
        c_has  = 1'b1;
      end
    end
    p_free = '0;
    p_has  = 1'b0;
    for (int i = PEND_DEPTH - 1; i >= 0; i--) begin
      if (!pend_valid[i]) begin
        p_free = PIDX_W'(i);
        p_has  = 1'b1;
      end
    end
    sel_slot = '0;
    sel_ok   = 1'b0;
    for (int i = 0; i < PEND_DEPTH; i++) begin
      if (snap_valid[i] && snap_rank[i] == k) begin
        sel_slot = PIDX_W'(i);
        sel_ok   = 1'b1;
      end
    end
  end

  always_comb begin
    due     = (p_rd.sends == 3'd0) || ((seconds_now - p_rd.sent_at) > {24'd0, retry_gap});
    give_up = p_rd.sends >= send_limit;
    c_raddr = cnt[CIDX_W-1:0];
    p_raddr = (state == ST_TSEL) ? sel_slot : cnt[PIDX_W-1:0];
    c_we    = (state == ST_FINISH) && (cur.cmd == CMD_INSERT) && c_has;
    c_wdata = '{ip: cur.ip_addr, mac: cur.mac_addr, stamp: seconds_now};
    q_pkts  = '0;
    p_we    = 1'b0;
    p_waddr = best_slot;
    p_wdata = best_word;
    if (state == ST_FINISH && cur.cmd == CMD_QUEUE) begin
      if (found) begin
        q_pkts = (cur.with_packet && best_word.packets != 8'hFF) ?
                 best_word.packets + 8'd1 : best_word.packets;
        p_we   = 1'b1;
        p_wdata.packets = q_pkts;
      end else if (p_has) begin
        q_pkts  = {7'd0, cur.with_packet};
        p_we    = 1'b1;
        p_waddr = p_free;
        p_wdata = '{ip: cur.ip_addr, sends: 3'd0, sent_at: seconds_now, packets: q_pkts};
      end
    end else if (state == ST_TEVAL && due && !give_up) begin
      p_we    = 1'b1;
      p_waddr = tslot;
      p_wdata = p_rd;
      p_wdata.sent_at = seconds_now;
      p_wdata.sends   = p_rd.sends + 3'd1;
    end
  end

  always_comb begin
    result_next       = '0;
    result_valid_next = 1'b0;
    unique case (state)
      ST_FINISH: begin
        result_valid_next  = 1'b1;
        result_next.ip_out = cur.ip_addr;
        result_next.last   = 1'b1;
        unique case (cur.cmd)
          CMD_LOOKUP: begin
            result_next.kind    = hit ? KIND_HIT : KIND_MISS;
            result_next.mac_out = hit ? hit_mac : 48'd0;
          end
          CMD_INSERT: begin
            result_next.kind          = KIND_INSERTED;
            result_next.stored        = c_has;
            result_next.pending_found = found;
            result_next.packet_count  = found ? best_word.packets : 8'd0;
          end
          CMD_QUEUE: begin
            result_next.kind         = KIND_QUEUED;
            result_next.stored       = found || p_has;
            result_next.packet_count = q_pkts;
          end
          default: result_next.kind = KIND_TICK_DONE;
        endcase
      end
      ST_TEVAL: begin
        if (due) begin
          result_valid_next        = 1'b1;
          result_next.ip_out       = p_rd.ip;
          result_next.packet_count = p_rd.packets;
          result_next.kind         = give_up ? KIND_GIVE_UP : KIND_SEND;
        end
      end
      ST_TDONE: begin
        result_valid_next = 1'b1;
        result_next.kind  = KIND_TICK_DONE;
        result_next.last  = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    c_rd <= cmem[c_raddr];
    if (c_we) begin
      cmem[c_free] <= c_wdata;
    end
    p_rd <= pmem[p_raddr];
    if (p_we) begin
      pmem[p_waddr] <= p_wdata;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = (item.cmd == CMD_INSERT || item.cmd == CMD_QUEUE) ?
                       ST_PSCAN : ST_CSCAN;
        end
      end
      ST_CSCAN: begin
        if (cnt == CCNT_W'(CACHE_DEPTH)) begin
          state_next = (cur.cmd == CMD_TICK) ? ST_TSEL : ST_FINISH;
        end
      end
      ST_PSCAN: begin
        if (cnt == CCNT_W'(PEND_DEPTH)) state_next = ST_FINISH;
      end
      ST_FINISH: state_next = ST_IDLE;
      ST_TSEL: begin
        if (sel_ok) state_next = ST_TEVAL;
        else if (k_last) state_next = ST_TDONE;
      end
      ST_TEVAL: state_next = k_last ? ST_TDONE : ST_TSEL;
      ST_TDONE: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy      = (state != ST_IDLE);
    cfg_ready = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      entry_lifetime <= 16'd15;
      send_limit     <= 3'd5;
      retry_gap      <= 8'd1;
      seconds_now    <= '0;
      entry_valid    <= '0;
      pend_valid     <= '0;
      result_valid   <= 1'b0;
      rv             <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
      if (result_valid_next) result <= result_next;
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_LIFETIME:   entry_lifetime <= cfg_data;
          CFG_SEND_LIMIT: send_limit     <= cfg_data[2:0];
          CFG_RETRY_GAP:  retry_gap      <= cfg_data[7:0];
          default: ;
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          cnt   <= '0;
          rv    <= 1'b0;
          hit   <= 1'b0;
          found <= 1'b0;
          k     <= '0;
          if (start) begin
            cur <= item;
            if (item.cmd == CMD_TICK) seconds_now <= seconds_now + 32'd1;
          end
        end
        ST_CSCAN: begin
          rv   <= (cnt < CCNT_W'(CACHE_DEPTH));
          ridx <= cnt[CIDX_W-1:0];
          if (cnt < CCNT_W'(CACHE_DEPTH)) cnt <= cnt + 1'b1;
          if (rv && entry_valid[ridx]) begin
            if (cur.cmd == CMD_TICK) begin
              if ((seconds_now - c_rd.stamp) > {16'd0, entry_lifetime}) begin
                entry_valid[ridx] <= 1'b0;
              end
            end else if (c_rd.ip == cur.ip_addr) begin
              hit     <= 1'b1;
              hit_mac <= c_rd.mac;
            end
          end
          snap_valid <= pend_valid;
          snap_rank  <= pend_rank;
        end
        ST_PSCAN: begin
          rv   <= (cnt < CCNT_W'(PEND_DEPTH));
          ridx <= cnt[CIDX_W-1:0];
          if (cnt < CCNT_W'(PEND_DEPTH)) cnt <= cnt + 1'b1;
          if (rv && pend_valid[pidx] && p_rd.ip == cur.ip_addr &&
              (!found || pend_rank[pidx] < best_rank)) begin
            found     <= 1'b1;
            best_slot <= pidx;
            best_rank <= pend_rank[pidx];
            best_word <= p_rd;
          end
        end
        ST_FINISH: begin
          unique case (cur.cmd)
            CMD_INSERT: begin
              if (c_has) entry_valid[c_free] <= 1'b1;
              if (found) begin
                for (int i = 0; i < PEND_DEPTH; i++) begin
                  if (pend_valid[i] && pend_rank[i] > best_rank) begin
                    pend_rank[i] <= pend_rank[i] - 1'b1;
                  end
                end
                pend_valid[best_slot] <= 1'b0;
              end
            end
            CMD_QUEUE: begin
              if (!found && p_has) begin
                for (int i = 0; i < PEND_DEPTH; i++) begin
                  if (pend_valid[i]) pend_rank[i] <= pend_rank[i] + 1'b1;
                end
                pend_rank[p_free]  <= '0;
                pend_valid[p_free] <= 1'b1;
              end
            end
            default: ;
          endcase
        end
        ST_TSEL: begin
          tslot <= sel_slot;
          if (!sel_ok) k <= k + 1'b1;
        end
        ST_TEVAL: begin
          k <= k + 1'b1;
          if (due && give_up) begin
            for (int i = 0; i < PEND_DEPTH; i++) begin
              if (pend_valid[i] && pend_rank[i] > pend_rank[tslot]) begin
                pend_rank[i] <= pend_rank[i] - 1'b1;
              end
            end
            pend_valid[tslot] <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== design/arpc_checker.sv =====
// Port-level checks for the ARP cache core, bound to the top level.
// Depends on arpc_pkg.
`timescale 1ns / 1ps
module arpc_checker import arpc_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input logic    result_valid,
  input result_t result
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("accepted item did not raise busy");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !result_valid && !busy) else $error("activity right after reset");

  a_mac_only_hit: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.kind != KIND_HIT |-> result.mac_out == 48'd0)
    else $error("mac on non-hit beat");

  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last |-> !busy) else $error("busy on last beat");

  a_midbeat_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last |-> busy) else $error("idle before last beat");

endmodule

bind arp_cache_with_request_retry_core arpc_checker u_arpc_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy),
  .result_valid(result_valid), .result(result)
);
